/* src/fac_pkg.sv */
package fac_pkg;

   localparam int SAMPLE_BITS     = 24;
   localparam int TABLE_ADDR_BITS = 8;
   localparam int TBL_SIZE        = 1 << TABLE_ADDR_BITS;
   localparam int ENV_BITS        = 32;
   localparam int GR_BITS         = 14;
   localparam int LOG_BITS        = 16;
   localparam int EXP_BITS        = 31;
   localparam int CSR_ADDR_BITS   = 5;
   localparam int CSR_DATA_BITS   = 32;

   localparam int COEF_BITS   = 24;
   localparam int THR_BITS    = 15;
   localparam int SLOPE_BITS  = 16;
   localparam int MAKEUP_BITS = 20;

   localparam logic [ENV_BITS-1:0] FLOOR_LIMIT  = 32'd2148;
   localparam logic [14:0]         FLOOR_DB_MAG = 15'd30720;
   localparam logic [31:0]         K_DB_PER_LOG2_Q16 = 32'd394566;
   localparam logic [31:0]         K_LOG2_PER_DB_Q20 = 32'd174165;
   localparam logic [GR_BITS-1:0]  GR_MAX = 14'd16383;

   localparam logic [COEF_BITS-1:0]   ATTACK_RESET  = 24'd16742299;
   localparam logic [COEF_BITS-1:0]   RELEASE_RESET = 24'd16773721;
   localparam logic [THR_BITS-1:0]    THR_RESET     = 15'h6C00;
   localparam logic [SLOPE_BITS-1:0]  SLOPE_RESET   = 16'd49152;
   localparam logic [MAKEUP_BITS-1:0] MAKEUP_RESET  = 20'd65536;

   localparam logic [2:0] REG_ATTACK  = 3'd0;
   localparam logic [2:0] REG_RELEASE = 3'd1;
   localparam logic [2:0] REG_THRESH  = 3'd2;
   localparam logic [2:0] REG_SLOPE   = 3'd3;
   localparam logic [2:0] REG_MAKEUP  = 3'd4;

   typedef struct packed {
      logic [COEF_BITS-1:0]   attack_coef;
      logic [COEF_BITS-1:0]   release_coef;
      logic [THR_BITS-1:0]    threshold_db;
      logic [SLOPE_BITS-1:0]  ratio_slope;
      logic [MAKEUP_BITS-1:0] makeup_gain;
   } cfg_type;

   typedef logic [LOG_BITS-1:0] log_tbl_type [TBL_SIZE];
   typedef logic [EXP_BITS-1:0] exp_tbl_type [TBL_SIZE];

   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = val;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (b > v) b = b >> 2;
      end
      for (int k = 0; k < 32; k++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // log2(1 + i/N) fraction by repeated squaring, truncated
   function automatic log_tbl_type build_log();
      log_tbl_type t;
      logic [63:0] m;
      logic [LOG_BITS-1:0] frac;
      for (int i = 0; i < TBL_SIZE; i++) begin
         m = (64'd1 << 30) + (64'(i) << (30 - TABLE_ADDR_BITS));
         frac = '0;
         for (int k = 0; k < LOG_BITS; k++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
               frac[0] = 1'b1;
               m = m >> 1;
            end
         end
         t[i] = frac;
      end
      return t;
   endfunction

   // 2^(i/N) in Q1.30 from products of nested square roots
   function automatic exp_tbl_type build_exp();
      exp_tbl_type t;
      logic [63:0] roots [TABLE_ADDR_BITS+1];
      logic [63:0] v;
      roots[0] = 64'd1 << 31;
      for (int k = 1; k <= TABLE_ADDR_BITS; k++) begin
         roots[k] = isqrt64(roots[k-1] << 30);
      end
      for (int i = 0; i < TBL_SIZE; i++) begin
         v = 64'd1 << 30;
         for (int k = 1; k <= TABLE_ADDR_BITS; k++) begin
            if (((i >> (TABLE_ADDR_BITS - k)) & 1) != 0)
               v = (v * roots[k] + (64'd1 << 29)) >> 30;
         end
         t[i] = EXP_BITS'(v);
      end
      return t;
   endfunction

   localparam log_tbl_type LOG_TBL = build_log();
   localparam exp_tbl_type EXP_TBL = build_exp();

endpackage

/* src/fac_req_if.sv */
interface fac_req_if;
   logic                             valid;
   logic                             ready;
   logic [fac_pkg::SAMPLE_BITS-1:0]  sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

/* src/fac_rsp_if.sv */
interface fac_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [fac_pkg::SAMPLE_BITS-1:0]  output_sample;
   logic [fac_pkg::GR_BITS-1:0]      gain_reduction_db;
   logic                             clipped;

   modport source (output valid, output output_sample, output gain_reduction_db,
                   output clipped, input ready);
   modport sink (input valid, input output_sample, input gain_reduction_db,
                 input clipped, output ready);
endinterface

/* src/fac_csr.sv */
module fac_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fac_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [fac_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [fac_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   output fac_pkg::cfg_type                    cfg
);

   fac_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0] idx;
   logic       wr;

   assign idx = csr_paddr[4:2];
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            fac_pkg::REG_ATTACK:  cfg_in.attack_coef  = csr_pwdata[fac_pkg::COEF_BITS-1:0];
            fac_pkg::REG_RELEASE: cfg_in.release_coef = csr_pwdata[fac_pkg::COEF_BITS-1:0];
            fac_pkg::REG_THRESH:  cfg_in.threshold_db = csr_pwdata[fac_pkg::THR_BITS-1:0];
            fac_pkg::REG_SLOPE:   cfg_in.ratio_slope  = csr_pwdata[fac_pkg::SLOPE_BITS-1:0];
            fac_pkg::REG_MAKEUP:  cfg_in.makeup_gain  = csr_pwdata[fac_pkg::MAKEUP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         fac_pkg::REG_ATTACK:  csr_prdata = 32'(cfg_ff.attack_coef);
         fac_pkg::REG_RELEASE: csr_prdata = 32'(cfg_ff.release_coef);
         fac_pkg::REG_THRESH:  csr_prdata = 32'(cfg_ff.threshold_db);
         fac_pkg::REG_SLOPE:   csr_prdata = 32'(cfg_ff.ratio_slope);
         fac_pkg::REG_MAKEUP:  csr_prdata = 32'(cfg_ff.makeup_gain);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_coef  <= fac_pkg::ATTACK_RESET;
         cfg_ff.release_coef <= fac_pkg::RELEASE_RESET;
         cfg_ff.threshold_db <= fac_pkg::THR_RESET;
         cfg_ff.ratio_slope  <= fac_pkg::SLOPE_RESET;
         cfg_ff.makeup_gain  <= fac_pkg::MAKEUP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/feedforward_audio_compressor.sv */
// The result register loads in ST_OUT once rsp_ch is free; a wait on rsp_ch.ready holds it there.
// A new request is taken only after the last one leaves ST_OUT; the single shared 32x32 multiplier
// is used seven times per request, back to back at first, then each followed by a result step.
// req_ch.ready is high only while the sequencer is idle.
// Reset (synchronous, active high) clears the envelope, the sequencer, the result
// valid flag and loads the default compressor settings.
module feedforward_audio_compressor (
   input  logic                               clock,
   input  logic                               reset,
   fac_req_if.sink                            req_ch,
   fac_rsp_if.source                          rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fac_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [fac_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [fac_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   localparam int SB = fac_pkg::SAMPLE_BITS;
   localparam int TA = fac_pkg::TABLE_ADDR_BITS;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_MUL_CE  = 4'd1;
   localparam logic [3:0] ST_MUL_CA  = 4'd2;
   localparam logic [3:0] ST_ENV     = 4'd3;
   localparam logic [3:0] ST_LOG     = 4'd4;
   localparam logic [3:0] ST_MUL_DB  = 4'd5;
   localparam logic [3:0] ST_DB      = 4'd6;
   localparam logic [3:0] ST_MUL_ATT = 4'd7;
   localparam logic [3:0] ST_ATT     = 4'd8;
   localparam logic [3:0] ST_MUL_E   = 4'd9;
   localparam logic [3:0] ST_GAIN    = 4'd10;
   localparam logic [3:0] ST_MUL_G   = 4'd11;
   localparam logic [3:0] ST_TRUNC   = 4'd12;
   localparam logic [3:0] ST_MUL_M   = 4'd13;
   localparam logic [3:0] ST_OUT     = 4'd14;

   fac_pkg::cfg_type cfg;

   fac_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   logic [3:0]          state_ff, state_in;
   logic [31:0]         env_ff, env_in;
   logic                neg_ff;
   logic [SB-1:0]       mag_ff;
   logic [31:0]         a_ff;
   logic [24:0]         coef_ff;
   logic [63:0]         mul_ff;
   logic [63:0]         acc_ff;
   logic [21:0]         lmag_ff;
   logic                floor_ff;
   logic [15:0]         over_ff;
   logic [fac_pkg::GR_BITS-1:0]  att_ff;
   logic [fac_pkg::EXP_BITS-1:0] gain_ff;
   logic [SB-1:0]       t_ff;
   logic                rsp_valid_ff;
   logic [SB-1:0]       rsp_sample_ff;
   logic [fac_pkg::GR_BITS-1:0]  rsp_gr_ff;
   logic                rsp_clip_ff;

   logic [31:0]         mul_a, mul_b;
   logic                req_take, out_free;
   logic [SB-1:0]       mag_w;
   logic [31:0]         a_w;

   assign req_take = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign mag_w = req_ch.sample[SB-1] ? SB'(-req_ch.sample) : req_ch.sample;
   assign a_w   = 32'(mag_w) << (32 - SB);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff) inside
         ST_MUL_CE:  begin mul_a = 32'(coef_ff);  mul_b = env_ff; end
         ST_MUL_CA:  begin mul_a = 32'((25'd1 << 24) - coef_ff); mul_b = a_ff; end
         ST_MUL_DB:  begin mul_a = 32'(lmag_ff);  mul_b = fac_pkg::K_DB_PER_LOG2_Q16; end
         ST_MUL_ATT: begin mul_a = 32'(over_ff);  mul_b = 32'(cfg.ratio_slope); end
         ST_MUL_E:   begin mul_a = 32'(att_ff);   mul_b = fac_pkg::K_LOG2_PER_DB_Q20; end
         ST_MUL_G:   begin mul_a = 32'(mag_ff);   mul_b = 32'(gain_ff); end
         ST_MUL_M, ST_OUT: begin
            mul_a = 32'(t_ff);
            mul_b = 32'(cfg.makeup_gain);
         end
         default: ;
      endcase
   end

   // leading one of the envelope and log table lookup
   logic [4:0]  lead;
   logic [31:0] norm;
   logic [TA-1:0] log_idx;
   always_comb begin
      lead = '0;
      for (int i = 0; i < 32; i++) begin
         if (env_ff[i]) lead = 5'(i);
      end
      norm    = env_ff << (5'd31 - lead);
      log_idx = norm[30 -: TA];
   end

   // dB compare against threshold
   logic [14:0]        dbmag;
   logic signed [16:0] env_db, thr17, over;
   always_comb begin
      dbmag  = floor_ff ? fac_pkg::FLOOR_DB_MAG
                        : 15'((mul_ff + (64'd1 << 23)) >> 24);
      env_db = -$signed({2'b00, dbmag});
      thr17  = 17'($signed(cfg.threshold_db));
      over   = env_db - thr17;
   end

   logic [63:0] q_w;
   assign q_w = (mul_ff + (64'd1 << 15)) >> 16;

   // attenuation to linear gain
   logic [20:0] e_w;
   logic [4:0]  n_w;
   logic [15:0] f_w;
   logic [15:0] f_neg;
   logic [5:0]  n1_w;
   logic [fac_pkg::EXP_BITS-1:0] gain_w;
   always_comb begin
      e_w    = 21'((mul_ff + (64'd1 << 11)) >> 12);
      n_w    = e_w[20:16];
      f_w    = e_w[15:0];
      f_neg  = 16'(17'h10000 - 17'(f_w));
      n1_w   = 6'(n_w) + 6'd1;
      if (f_w == 16'd0) begin
         gain_w = (n_w == 5'd31) ? '0 : (31'd1 << 30) >> n_w;
      end else if (n1_w >= 6'd31) begin
         gain_w = '0;
      end else begin
         gain_w = fac_pkg::EXP_TBL[f_neg[15 -: TA]] >> n1_w;
      end
   end

   // makeup, saturation, sign restore
   logic [63:0]   u_w;
   logic [63:0]   lim_w;
   logic [63:0]   usat_w;
   logic          clip_w;
   logic [SB-1:0] res_w;
   always_comb begin
      u_w    = (mul_ff + (64'd1 << 15)) >> 16;
      lim_w  = neg_ff ? (64'd1 << (SB - 1)) : ((64'd1 << (SB - 1)) - 64'd1);
      clip_w = u_w > lim_w;
      usat_w = clip_w ? lim_w : u_w;
      res_w  = neg_ff ? SB'(-usat_w) : SB'(usat_w);
   end

   always_comb begin
      env_in   = env_ff;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_take) state_in = ST_MUL_CE;
         ST_MUL_CE:  state_in = ST_MUL_CA;
         ST_MUL_CA:  state_in = ST_ENV;
         ST_ENV: begin
            env_in   = 32'((65'(acc_ff) + 65'(mul_ff) + (65'd1 << 23)) >> 24);
            state_in = ST_LOG;
         end
         ST_LOG:     state_in = ST_MUL_DB;
         ST_MUL_DB:  state_in = ST_DB;
         ST_DB:      state_in = ST_MUL_ATT;
         ST_MUL_ATT: state_in = ST_ATT;
         ST_ATT:     state_in = ST_MUL_E;
         ST_MUL_E:   state_in = ST_GAIN;
         ST_GAIN:    state_in = ST_MUL_G;
         ST_MUL_G:   state_in = ST_TRUNC;
         ST_TRUNC:   state_in = ST_MUL_M;
         ST_MUL_M:   state_in = ST_OUT;
         ST_OUT:     if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         env_ff   <= env_in;
         if (state_ff == ST_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= 64'(mul_a) * 64'(mul_b);
      if (req_take) begin
         neg_ff  <= req_ch.sample[SB-1];
         mag_ff  <= mag_w;
         a_ff    <= a_w;
         coef_ff <= 25'((a_w > env_ff) ? cfg.attack_coef : cfg.release_coef);
      end
      if (state_ff == ST_MUL_CA) acc_ff <= mul_ff;
      if (state_ff == ST_LOG) begin
         floor_ff <= env_ff < fac_pkg::FLOOR_LIMIT;
         lmag_ff  <= (22'(5'd31 - lead) << 16) - 22'(fac_pkg::LOG_TBL[log_idx]);
      end
      if (state_ff == ST_DB) over_ff <= (env_db > thr17) ? over[15:0] : 16'd0;
      if (state_ff == ST_ATT)
         att_ff <= (q_w > 64'(fac_pkg::GR_MAX)) ? fac_pkg::GR_MAX : q_w[fac_pkg::GR_BITS-1:0];
      if (state_ff == ST_GAIN) gain_ff <= gain_w;
      if (state_ff == ST_TRUNC) t_ff <= SB'((mul_ff + (64'd1 << 29)) >> 30);
      if (state_ff == ST_OUT && out_free) begin
         rsp_sample_ff <= res_w;
         rsp_gr_ff     <= att_ff;
         rsp_clip_ff   <= clip_w;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.output_sample     = rsp_sample_ff;
   assign rsp_ch.gain_reduction_db = rsp_gr_ff;
   assign rsp_ch.clipped           = rsp_clip_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_MUL_CE)
      else $error("request accept did not start the sequencer");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL_G |-> gain_ff <= (31'd1 << 30))
      else $error("gain above unity");

   a_clip_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.clipped |->
         rsp_ch.output_sample == {1'b0, {(SB-1){1'b1}}} ||
         rsp_ch.output_sample == {1'b1, {(SB-1){1'b0}}})
      else $error("clip flag without full-scale output");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && !out_free |=> state_ff == ST_OUT && $stable(t_ff))
      else $error("result lost while output busy");

endmodule

/* bench/fac_test_if.sv */
`timescale 1ns / 1ps
// Interfaces are supplied with the RTL (fac_req_if, fac_rsp_if); this file holds
// the stimulus-row and expected-result types shared by the bench.
package fac_test_pkg;
   import fac_pkg::*;

   typedef struct {
      logic [SAMPLE_BITS-1:0] sample;
      bit                     known;     // expected result typed in
      logic [SAMPLE_BITS-1:0] out_sample;
      logic [GR_BITS-1:0]     gr;
      logic                   clip;
   } stim_row_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] out_sample;
      logic [GR_BITS-1:0]     gr;
      logic                   clip;
   } comp_result_type;
endpackage

/* bench/feedforward_audio_compressor_test.sv */
`timescale 1ns / 1ps
module feedforward_audio_compressor_test;
   import fac_pkg::*;
   import fac_test_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 550;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   fac_req_if req_ch ();
   fac_rsp_if rsp_ch ();

   feedforward_audio_compressor dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [31:0] pr_attack, pr_release, pr_slope, pr_makeup, pr_env;
   int          pr_thresh;
   logic [15:0] log_lut [TBL_SIZE];
   logic [30:0] exp_lut [TBL_SIZE];

   comp_result_type expected_q[$];
   bit  failed = 0;
   int  idle_cycles = 0;
   bit  rsp_run = 0;

   function automatic logic [63:0] sqrt_floor(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   task automatic fill_luts();
      logic [63:0] roots [TABLE_ADDR_BITS+1];
      logic [63:0] m, v;
      logic [15:0] frac;
      roots[0] = 64'd1 << 31;
      for (int k = 1; k <= TABLE_ADDR_BITS; k++) roots[k] = sqrt_floor(roots[k-1] << 30);
      for (int i = 0; i < TBL_SIZE; i++) begin
         m = (64'd1 << 30) + (64'(i) << (30 - TABLE_ADDR_BITS));
         frac = 0;
         v = 64'd1 << 30;
         for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
               frac[0] = 1'b1;
               m >>= 1;
            end
         end
         log_lut[i] = frac;
         for (int k = 1; k <= TABLE_ADDR_BITS; k++)
            if ((i >> (TABLE_ADDR_BITS - k)) & 1) v = (v * roots[k] + (64'd1 << 29)) >> 30;
         exp_lut[i] = v[30:0];
      end
   endtask

   function automatic logic [31:0] level_db_mag(logic [31:0] env);
      int p;
      int idx;
      logic [63:0] lmag;
      if (env < FLOOR_LIMIT) return 32'd30720;
      p = 31;
      while (env[p] == 1'b0) p--;
      if (p >= TABLE_ADDR_BITS) idx = (env >> (p - TABLE_ADDR_BITS)) & (TBL_SIZE - 1);
      else idx = (env << (TABLE_ADDR_BITS - p)) & (TBL_SIZE - 1);
      lmag = (64'(31 - p) << 16) - log_lut[idx];
      return 32'((lmag * 64'd394566 + (64'd1 << 23)) >> 24);
   endfunction

   function automatic logic [63:0] atten_gain(logic [31:0] att);
      logic [63:0] e, n;
      logic [15:0] f;
      e = (64'(att) * 64'd174165 + 64'd2048) >> 12;
      n = e >> 16;
      f = e[15:0];
      if (f == 0) return n >= 31 ? 64'd0 : ((64'd1 << 30) >> n);
      if (n + 1 >= 31) return 64'd0;
      return 64'(exp_lut[(32'd65536 - f) >> (16 - TABLE_ADDR_BITS)]) >> (n + 1);
   endfunction

   function automatic comp_result_type compress_sample(logic [SAMPLE_BITS-1:0] s);
      comp_result_type r;
      logic        neg;
      logic [63:0] mag, a, c, t, u, lim, q;
      int          env_db, over;
      logic [31:0] att;
      neg = s[SAMPLE_BITS-1];
      mag = neg ? ((64'd1 << SAMPLE_BITS) - s) : 64'(s);
      a = mag << (32 - SAMPLE_BITS);
      c = (a > pr_env) ? pr_attack : pr_release;
      pr_env = 32'((c * pr_env + ((64'd1 << 24) - c) * a + (64'd1 << 23)) >> 24);
      env_db = -int'(level_db_mag(pr_env));
      att = 0;
      if (env_db > pr_thresh) begin
         over = env_db - pr_thresh;
         q = (64'(over) * pr_slope + 64'd32768) >> 16;
         att = q > 16383 ? 16383 : 32'(q);
      end
      t = (mag * atten_gain(att) + (64'd1 << 29)) >> 30;
      u = (t * pr_makeup + 64'd32768) >> 16;
      lim = neg ? (64'd1 << (SAMPLE_BITS - 1)) : ((64'd1 << (SAMPLE_BITS - 1)) - 1);
      r.clip = 1'b0;
      if (u > lim) begin
         u = lim;
         r.clip = 1'b1;
      end
      r.out_sample = neg ? SAMPLE_BITS'((64'd1 << SAMPLE_BITS) - u) : SAMPLE_BITS'(u);
      r.gr = att[GR_BITS-1:0];
      return r;
   endfunction

   task automatic load_defaults();
      pr_attack = ATTACK_RESET;
      pr_release = RELEASE_RESET;
      pr_thresh = int'($signed(THR_RESET));
      pr_slope = SLOPE_RESET;
      pr_makeup = MAKEUP_RESET;
      pr_env = 0;
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_BITS'(idx) << 2;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_ATTACK:  pr_attack = val[23:0];
         REG_RELEASE: pr_release = val[23:0];
         REG_THRESH:  pr_thresh = int'($signed(val[14:0]));
         REG_SLOPE:   pr_slope = val[15:0];
         REG_MAKEUP:  pr_makeup = val[19:0];
         default: ;
      endcase
   endtask

   // valid stays high into the next request when no idle cycles are drawn
   task automatic drive_request(logic [SAMPLE_BITS-1:0] s);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.sample <= s;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_sample(logic [SAMPLE_BITS-1:0] s);
      drive_request(s);
      expected_q.push_back(compress_sample(s));
   endtask

   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // result side: random stalls per request, with occasional no-stall runs
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = rsp_run ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if ($urandom_range(0, 31) == 0) rsp_run = !rsp_run;
      end
   end

   always @(posedge clock) begin
      comp_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t unexpected result: %h", $time, rsp_ch.output_sample);
            failed = 1;
         end else begin
            want = expected_q.pop_front();
            if (rsp_ch.output_sample !== want.out_sample) begin
               $display("%0t output_sample expected %h actual %h", $time,
                        want.out_sample, rsp_ch.output_sample);
               failed = 1;
            end
            if (rsp_ch.gain_reduction_db !== want.gr) begin
               $display("%0t gain_reduction_db expected %0d actual %0d", $time,
                        want.gr, rsp_ch.gain_reduction_db);
               failed = 1;
            end
            if (rsp_ch.clipped !== want.clip) begin
               $display("%0t clipped expected %b actual %b", $time,
                        want.clip, rsp_ch.clipped);
               failed = 1;
            end
         end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_psel)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   stim_row_type directed [] = '{
      '{24'h000000, 1, 24'h000000, 14'd0, 1'b0},
      '{24'h7FFFFF, 0, 0, 0, 0},
      '{24'h800000, 0, 0, 0, 0},
      '{24'h000001, 0, 0, 0, 0},
      '{24'hFFFFFF, 0, 0, 0, 0},
      '{24'h400000, 0, 0, 0, 0},
      '{24'hC00000, 0, 0, 0, 0},
      '{24'h000000, 0, 0, 0, 0}
   };

   task automatic run_directed();
      comp_result_type r;
      foreach (directed[i]) begin
         if (directed[i].known) begin
            // typed-in row: expected result from the table, predictor still advances
            drive_request(directed[i].sample);
            r = compress_sample(directed[i].sample);
            r.out_sample = directed[i].out_sample;
            r.gr = directed[i].gr;
            r.clip = directed[i].clip;
            expected_q.push_back(r);
         end else send_sample(directed[i].sample);
      end
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return SAMPLE_BITS'($urandom);
         1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         2: return SAMPLE_BITS'($urandom_range(0, 255)) ^ {24{$urandom_range(0, 1) == 1}};
         default: return SAMPLE_BITS'($urandom) >>> $urandom_range(0, 12);
      endcase
   endfunction

   initial begin
      req_ch.valid = 1'b0;
      req_ch.sample = '0;
      fill_luts();
      load_defaults();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      wait_drain();
      // extremes: fast envelope, hard compression, max makeup, lowest threshold
      csr_write(REG_ATTACK, 32'd0);
      csr_write(REG_RELEASE, 32'hFF000000);
      csr_write(REG_THRESH, 32'(-15360) & 32'h7FFF);
      csr_write(REG_SLOPE, 32'd62259);
      csr_write(REG_MAKEUP, 32'd1038694);
      csr_write(REG_UNUSED, 32'hFFFFFFFF);
      for (int i = 0; i < 10; i++) send_sample(pick_sample());
      send_sample(24'h7FFFFF);
      send_sample(24'h800000);
      wait_drain();
      csr_write(REG_THRESH, 32'd0);
      csr_write(REG_SLOPE, 32'd0);
      csr_write(REG_RELEASE, 32'd16777215);
      csr_write(REG_ATTACK, 32'd16777215);
      send_sample(24'h7FFFFF);
      send_sample(24'h800000);
      wait_drain();
      for (int phase = 0; phase < 5; phase++) begin
         csr_write(REG_ATTACK, $urandom_range(0, 16777215));
         csr_write(REG_RELEASE, $urandom_range(16000000, 16777215));
         csr_write(REG_THRESH, 32'($urandom_range(0, 15360) * -1) & 32'h7FFF);
         csr_write(REG_SLOPE, $urandom_range(0, 62259));
         csr_write(REG_MAKEUP, $urandom_range(65536, 1038694));
         for (int i = 0; i < RANDOM_ITEMS / 5; i++) send_sample(pick_sample());
         wait_drain();
      end
      if (!failed && expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
